/* rtl/rgba_box_filter_half_scale_defines.svh */
// Assertion macros for the 2x2 box filter half-scale block.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef RGBA_BOX_FILTER_HALF_SCALE_DEFINES_SVH
`define RGBA_BOX_FILTER_HALF_SCALE_DEFINES_SVH

// Checked on every edge outside reset.
`define BFHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BFHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bfhs_pkg.sv */
// Shared types, constants and channel arithmetic for the 2x2 box filter.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package bfhs_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_W     = 8;
  localparam int SUM_W    = 10;
  localparam int PIX_W    = NUM_CH * CH_W;
  localparam int PAIR_W   = NUM_CH * SUM_W;
  localparam int DIM_REG_W = 12;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = DIM_REG_W'(2);
  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = DIM_REG_W'(2);

  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(2);

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [DIM_REG_W-1:0] dim_reg_t;

  typedef enum logic [0:0] {
    CFG_SOURCE_WIDTH  = 1'b0,
    CFG_SOURCE_HEIGHT = 1'b1
  } cfg_idx_t;

  // Per-channel sums of two pixels, four 10-bit fields.
  function automatic pair_t pair_sum(input pixel_t a, input pixel_t b);
    pair_t r;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      r[ch*SUM_W +: SUM_W] = SUM_W'(a[ch*CH_W +: CH_W]) + SUM_W'(b[ch*CH_W +: CH_W]);
    end
    return r;
  endfunction

  // Rounded 2x2 average from two pair sums: (top + bottom + 2) >> 2.
  function automatic pixel_t average(input pair_t top, input pair_t bottom);
    pixel_t r;
    logic [SUM_W:0] s;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s = (SUM_W+1)'(top[ch*SUM_W +: SUM_W]) + (SUM_W+1)'(bottom[ch*SUM_W +: SUM_W])
        + (SUM_W+1)'(ROUND_BIAS);
      r[ch*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/bfhs_chan_if.sv */
// Valid/ready channels of the box filter: source pixels in, filtered pixels out.
// Depends on bfhs_pkg for the pixel type.
`default_nettype none

interface bfhs_in_if;
  logic              valid;
  logic              ready;
  bfhs_pkg::pixel_t  source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface bfhs_out_if;
  logic              valid;
  logic              ready;
  bfhs_pkg::pixel_t  filtered_pixel;
  logic              last_of_image;

  modport source (output valid, output filtered_pixel, output last_of_image, input ready);
  modport sink   (input valid, input filtered_pixel, input last_of_image, output ready);
endinterface

`default_nettype wire

/* rtl/rgba_box_filter_half_scale.sv */
// 2x2 box filter half-scale downsampler for packed 8-bit RGBA, top level.
// Depends on bfhs_pkg, bfhs_chan_if.sv and rgba_box_filter_half_scale_defines.svh.
`default_nettype none

// Source pixels enter one item per clock in row-major order; with the output
// taken every cycle the block sustains one item per clock without a gap. A
// result is held first in the pipeline register, which is loaded when the item
// that completes its 2x2 block is accepted and the line-buffer read is issued,
// and then in the output register. Even rows store horizontal pair
// sums in a single-port line memory (MAX_WIDTH/2 entries of 40 bits); odd
// rows read the stored sum back and emit the rounded average per channel.
// A row never reads and writes the memory in the same cycle, so one port
// serves. Width 1 pairs a pixel with itself, height 1 uses its single row
// twice, and a leftover odd column or row is consumed silently. Register
// values of 0 act as 1 and values above MAX_WIDTH/MAX_HEIGHT saturate.
// Writing either register restarts the image; write only while idle. The
// line memory has no reset and needs no clearing pass: every entry is
// written in an even row before the following odd row reads it.
module rgba_box_filter_half_scale #(
  parameter int MAX_WIDTH  = bfhs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bfhs_pkg::DEF_MAX_HEIGHT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  bfhs_pkg::cfg_idx_t           cfg_index,
  input  wire [bfhs_pkg::DIM_REG_W-1:0] cfg_data,
  bfhs_in_if.sink                      in_chan,
  bfhs_out_if.source                   out_chan
);

  `include "rgba_box_filter_half_scale_defines.svh"

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CCNT_W     = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int RCNT_W     = ($clog2(MAX_HEIGHT) > 2) ? $clog2(MAX_HEIGHT) : 2;
  localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  bfhs_pkg::dim_reg_t width_r, height_r;

  // Image position and left pixel of the current pair
  logic [CCNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [RCNT_W-1:0] row_cnt_r, row_cnt_nxt;
  bfhs_pkg::pixel_t  left_r;

  // Line memory of pair sums
  bfhs_pkg::pair_t   line_mem [LINE_DEPTH];
  bfhs_pkg::pair_t   rd_data_r;

  // Pipeline stage between accept and output
  logic              s1_valid_r, s1_valid_nxt;
  bfhs_pkg::pair_t   s1_pair_r;
  logic              s1_line_r;
  logic              s1_last_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  bfhs_pkg::pixel_t  out_pixel_r;
  logic              out_last_r;

  // Effective dimensions
  logic [WDIM_W-1:0] width_eff, width_even, dw_m1;
  logic [HDIM_W-1:0] height_eff, height_even, dh_m1;
  logic              fw, fh;

  logic              in_acc, s1_adv;
  logic              col_ok, row_ok, in_image, have_pair, emit;
  logic              line_we, line_re, last_flag;
  logic              col_wrap, row_wrap;
  logic [LINE_AW-1:0] line_idx;
  logic [RCNT_W-1:0] out_row;
  bfhs_pkg::pair_t   pair_in;
  bfhs_pkg::pair_t   top_sum;

  // ---------------------------------------------------------------
  // Dimension clamp: 0 reads as 1, oversize saturates
  // ---------------------------------------------------------------
  always_comb begin
    if (width_r == '0) begin
      width_eff = WDIM_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      width_eff = WDIM_W'(MAX_WIDTH);
    end else begin
      width_eff = WDIM_W'(width_r);
    end
    if (height_r == '0) begin
      height_eff = HDIM_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      height_eff = HDIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = HDIM_W'(height_r);
    end
    fw          = (width_eff != WDIM_W'(1));
    fh          = (height_eff != HDIM_W'(1));
    width_even  = {width_eff[WDIM_W-1:1], 1'b0};
    height_even = {height_eff[HDIM_W-1:1], 1'b0};
    dw_m1       = fw ? (width_eff >> 1) - WDIM_W'(1) : '0;
    dh_m1       = fh ? (height_eff >> 1) - HDIM_W'(1) : '0;
  end

  // ---------------------------------------------------------------
  // Accept stage: pairing, line memory access, counter advance
  // ---------------------------------------------------------------
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc       = in_chan.valid && in_chan.ready;

  always_comb begin
    col_ok    = fw ? (WDIM_W'(col_cnt_r) < width_even) : (col_cnt_r == '0);
    row_ok    = fh ? (HDIM_W'(row_cnt_r) < height_even) : (row_cnt_r == '0);
    in_image  = col_ok && row_ok;
    // second pixel of a horizontal pair (or any pixel at width 1)
    have_pair = in_image && (!fw || col_cnt_r[0]);
    pair_in   = fw ? bfhs_pkg::pair_sum(left_r, in_chan.source_pixel)
                   : bfhs_pkg::pair_sum(in_chan.source_pixel, in_chan.source_pixel);
    line_idx  = fw ? LINE_AW'(col_cnt_r >> 1) : '0;
    out_row   = fh ? (row_cnt_r >> 1) : '0;
    line_we   = in_acc && have_pair && fh && !row_cnt_r[0];
    line_re   = in_acc && have_pair && fh && row_cnt_r[0];
    emit      = have_pair && (!fh || row_cnt_r[0]);
    last_flag = (WDIM_W'(line_idx) == dw_m1) && (HDIM_W'(out_row) == dh_m1);
  end

  // Position counters; a row ends at the last column, the image at the last row
  always_comb begin
    col_wrap    = (WDIM_W'(col_cnt_r) == width_eff - WDIM_W'(1));
    row_wrap    = (HDIM_W'(row_cnt_r) == height_eff - HDIM_W'(1));
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_we) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_wrap ? '0 : row_cnt_r + RCNT_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= bfhs_pkg::WIDTH_RESET;
      height_r  <= bfhs_pkg::HEIGHT_RESET;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      left_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bfhs_pkg::CFG_SOURCE_WIDTH:  width_r  <= cfg_data;
          bfhs_pkg::CFG_SOURCE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (in_acc && in_image && fw && !col_cnt_r[0]) begin
        left_r <= in_chan.source_pixel;
      end
    end
  end

  // Single-port line memory, registered read
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_idx] <= pair_in;
    end
    if (line_re) begin
      rd_data_r <= line_mem[line_idx];
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: average, then output register
  // ---------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // height 1 averages the row pair with itself
  assign top_sum = s1_line_r ? rd_data_r : s1_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      s1_pair_r <= pair_in;
      s1_line_r <= fh;
      s1_last_r <= last_flag;
    end
    if (s1_adv) begin
      out_pixel_r <= bfhs_pkg::average(top_sum, s1_pair_r);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.filtered_pixel = out_pixel_r;
  assign out_chan.last_of_image  = out_last_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `BFHS_ASSERT(a_no_take_when_full, (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready, "input taken while pipeline blocked")
  `BFHS_ASSERT(a_line_one_port, !(line_we && line_re), "line memory read and write in one cycle")
  `BFHS_ASSERT(a_col_in_range, WDIM_W'(col_cnt_r) < width_eff, "column counter beyond row width")
  `BFHS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_chan.valid, "output valid right after reset")

endmodule

`default_nettype wire
